[rtl/core/ctbl_pkg.sv]
// shared types and constants for the cubic table interpolator
package ctbl_pkg;

    localparam int SAMPLE_W  = 16;   // table entry and result width, Q1.15
    localparam int X_W       = 16;   // argument width, Q1.15
    localparam int FRAC_BITS = 16;   // fraction bits of the table position
    localparam int T_W       = 16;   // interpolation fraction width
    localparam int ADDR_W    = 10;   // write address width on the stream
    localparam int LEN_W     = 11;   // table length register width
    localparam int CFG_W     = 32;   // widest configuration register
    localparam int IDX_W     = 16;   // table index width, covers the deepest store
    localparam int CFG_IDX_W = 2;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int ADDR_LSB  = 0;
    localparam int DATA_LSB  = ADDR_LSB + ADDR_W;
    localparam int X_LSB     = DATA_LSB + SAMPLE_W;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TBL_LEN  = 2'd2;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic                 req_type;
        logic [ADDR_W-1:0]    table_addr;
        logic signed [SAMPLE_W-1:0] table_data;
        logic signed [X_W-1:0]      x_value;
    } req_t;

    // item after position mapping: either a table write or a clamped lookup
    typedef struct packed {
        logic             is_write;
        logic             wr_ok;
        logic [IDX_W-1:0] idx;
        sample_t          wdata;
        logic [T_W-1:0]   t;
        logic             flag;
    } lookup_t;

    // four neighbouring entries around the position
    typedef struct packed {
        sample_t        m1;
        sample_t        p0;
        sample_t        p1;
        sample_t        p2;
        logic [T_W-1:0] t;
        logic           flag;
    } taps_t;

endpackage

[rtl/core/ctbl_mapper.sv]
// maps the argument to a clamped table index and fraction, three pipeline stages
module ctbl_mapper #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [ctbl_pkg::CFG_W-1:0]   x_scale,
    input  logic signed [ctbl_pkg::CFG_W-1:0]   x_offset,
    input  logic [ctbl_pkg::LEN_W-1:0]          tbl_len,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ctbl_pkg::req_t                      in_req,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ctbl_pkg::lookup_t                   out_lookup
);
    import ctbl_pkg::*;

    localparam int PROD_W = X_W + CFG_W;
    localparam int XQ     = X_W - 1;
    localparam int POS_W  = PROD_W - XQ + 1;
    localparam int IR_W   = POS_W - FRAC_BITS;

    localparam logic [IR_W-1:0] DEPTH_L = IR_W'(TABLE_DEPTH);
    localparam logic [IR_W-1:0] LEN_MIN = IR_W'(4);
    localparam logic [IR_W-1:0] TAIL    = IR_W'(3);

    logic a_en, b_en, c_en;

    logic a_valid_reg;
    req_t a_req_reg;

    logic                       b_valid_reg;
    logic                       b_write_reg;
    logic [ADDR_W-1:0]          b_addr_reg;
    sample_t                    b_data_reg;
    logic signed [PROD_W-1:0]   b_prod_reg;
    logic signed [PROD_W-1:0]   prod_next;

    logic    c_valid_reg;
    lookup_t c_lookup_reg;
    lookup_t c_lookup_next;

    logic [IR_W-1:0]          len_ext, len_eff, idx_hi;
    logic signed [POS_W-1:0]  pos;
    logic [IR_W-1:0]          idx_raw;
    logic                     idx_low, idx_high;

    assign c_en     = !c_valid_reg || out_ready;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // usable index range from the table length
    assign len_ext = IR_W'(tbl_len);
    always_comb begin
        if (len_ext < LEN_MIN) begin
            len_eff = LEN_MIN;
        end else if (len_ext > DEPTH_L) begin
            len_eff = DEPTH_L;
        end else begin
            len_eff = len_ext;
        end
    end
    assign idx_hi = len_eff - TAIL;

    // stage a: input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_req_reg <= in_req;
        end
    end

    // stage b: argument times slope
    assign prod_next = PROD_W'($signed(a_req_reg.x_value)) * PROD_W'(x_scale);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            b_write_reg <= (a_req_reg.req_type == REQ_WRITE);
            b_addr_reg  <= a_req_reg.table_addr;
            b_data_reg  <= a_req_reg.table_data;
            b_prod_reg  <= prod_next;
        end
    end

    // stage c: add offset, split index and fraction, clamp
    assign pos      = POS_W'($signed(b_prod_reg[PROD_W-1:XQ])) + POS_W'(x_offset);
    assign idx_raw  = pos[POS_W-1:FRAC_BITS];
    assign idx_low  = idx_raw[IR_W-1] || (idx_raw == '0);
    assign idx_high = !idx_raw[IR_W-1] && (idx_raw > idx_hi);

    always_comb begin
        c_lookup_next          = '0;
        c_lookup_next.is_write = b_write_reg;
        c_lookup_next.wdata    = b_data_reg;
        c_lookup_next.wr_ok    = (IR_W'(b_addr_reg) < DEPTH_L);
        if (b_write_reg) begin
            c_lookup_next.idx = IDX_W'(b_addr_reg);
        end else if (idx_low) begin
            c_lookup_next.idx  = IDX_W'(1);
            c_lookup_next.flag = 1'b1;
        end else if (idx_high) begin
            c_lookup_next.idx  = idx_hi[IDX_W-1:0];
            c_lookup_next.flag = 1'b1;
        end else begin
            c_lookup_next.idx = idx_raw[IDX_W-1:0];
            c_lookup_next.t   = pos[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_lookup_reg <= c_lookup_next;
        end
    end

    assign out_valid  = c_valid_reg;
    assign out_lookup = c_lookup_reg;

    a_clamp_zero_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !c_lookup_reg.is_write && c_lookup_reg.flag
            |-> c_lookup_reg.t == '0)
        else $error("clamped lookup carries a nonzero fraction");

    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_en |=> b_valid_reg && $stable(b_prod_reg))
        else $error("stalled product stage lost its contents");

endmodule

[rtl/core/ctbl_store.sv]
// four-bank table store, one write or one four-entry read per transfer
module ctbl_store #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ctbl_pkg::lookup_t    in_lookup,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ctbl_pkg::taps_t      out_taps
);
    import ctbl_pkg::*;

    localparam int NB     = 4;
    localparam int BANK_W = 2;
    localparam int ROWS   = (TABLE_DEPTH + NB - 1) / NB;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AD_W   = IDX_W + 1;

    logic                en;
    logic                out_valid_reg;
    logic [BANK_W-1:0]   rot_reg;
    logic [T_W-1:0]      t_reg;
    logic                flag_reg;
    logic [IDX_W-1:0]    base;
    sample_t             rd_data [NB];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // first of the four neighbours; idx is at least one for a lookup
    assign base = in_lookup.idx - IDX_W'(1);

    // consecutive entries fall into distinct banks by the low address bits
    for (genvar b = 0; b < NB; b++) begin : g_bank
        sample_t             mem [ROWS];
        sample_t             rd_reg;
        logic [BANK_W-1:0]   off;
        logic [AD_W-1:0]     rd_addr;
        logic [ROW_W-1:0]    rd_row;
        logic [ROW_W-1:0]    wr_row;
        logic                wr_hit;

        assign off     = BANK_W'(b) - base[BANK_W-1:0];
        assign rd_addr = {1'b0, base} + AD_W'(off);
        assign rd_row  = rd_addr[BANK_W +: ROW_W];
        assign wr_row  = in_lookup.idx[BANK_W +: ROW_W];
        assign wr_hit  = in_valid && in_lookup.is_write && in_lookup.wr_ok
                         && (in_lookup.idx[BANK_W-1:0] == BANK_W'(b));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (wr_hit) begin
                    mem[wr_row] <= in_lookup.wdata;
                end
                rd_reg <= mem[rd_row];
            end
        end

        assign rd_data[b] = rd_reg;
    end

    // writes end here, only lookups move on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid && !in_lookup.is_write;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg  <= base[BANK_W-1:0];
            t_reg    <= in_lookup.t;
            flag_reg <= in_lookup.flag;
        end
    end

    // rotate bank outputs back into neighbour order
    always_comb begin
        out_taps.m1   = rd_data[rot_reg];
        out_taps.p0   = rd_data[rot_reg + BANK_W'(1)];
        out_taps.p1   = rd_data[rot_reg + BANK_W'(2)];
        out_taps.p2   = rd_data[rot_reg + BANK_W'(3)];
        out_taps.t    = t_reg;
        out_taps.flag = flag_reg;
    end

    assign out_valid = out_valid_reg;

    a_only_lookups: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && $past(en) |-> $past(in_valid && !in_lookup.is_write))
        else $error("store stage emitted an item that was not a lookup");

endmodule

[rtl/core/ctbl_hermite.sv]
// catmull-rom polynomial evaluation, seven pipeline stages ending in the output register
module ctbl_hermite (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ctbl_pkg::taps_t       in_taps,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ctbl_pkg::sample_t     y_value,
    output logic                  out_of_range
);
    import ctbl_pkg::*;

    localparam int NS    = 7;
    localparam int C1_W  = SAMPLE_W + 1;
    localparam int C_W   = SAMPLE_W + 4;
    localparam int TS_W  = T_W + 1;
    localparam int C3T_W = C_W + TS_W;
    localparam int V2_W  = C3T_W + 1;
    localparam int PV2_W = V2_W + TS_W;
    localparam int V1_W  = PV2_W - T_W + 1;
    localparam int PV1_W = V1_W + TS_W;
    localparam int Q_SH  = 2 * T_W + 1;
    localparam int Y_W   = PV1_W - Q_SH + 1;

    localparam logic signed [PV2_W-1:0] RND2  = PV2_W'(1) <<< (T_W - 1);
    localparam logic signed [PV1_W-1:0] RND1  = PV1_W'(1) <<< (Q_SH - 1);
    localparam logic signed [Y_W-1:0]   Y_MAX = Y_W'((1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [Y_W-1:0]   Y_MIN = ~Y_MAX;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // stage 1: coefficients
    logic signed [C1_W-1:0] c1_s1_reg;
    logic signed [C_W-1:0]  c2_s1_reg, c3_s1_reg;
    sample_t                p0_s1_reg;
    logic [T_W-1:0]         t_s1_reg;
    logic                   f_s1_reg;
    logic signed [C_W-1:0]  c2_next, c3_next, d_pp;

    // stage 2: c3 * t
    logic signed [C3T_W-1:0] c3t_s2_reg;
    logic signed [C1_W-1:0]  c1_s2_reg;
    logic signed [C_W-1:0]   c2_s2_reg;
    sample_t                 p0_s2_reg;
    logic [T_W-1:0]          t_s2_reg;
    logic                    f_s2_reg;

    // stage 3: v2
    logic signed [V2_W-1:0]  v2_s3_reg;
    logic signed [C1_W-1:0]  c1_s3_reg;
    sample_t                 p0_s3_reg;
    logic [T_W-1:0]          t_s3_reg;
    logic                    f_s3_reg;

    // stage 4: v2 * t
    logic signed [PV2_W-1:0] pv2_s4_reg;
    logic signed [C1_W-1:0]  c1_s4_reg;
    sample_t                 p0_s4_reg;
    logic [T_W-1:0]          t_s4_reg;
    logic                    f_s4_reg;

    // stage 5: v1
    logic signed [V1_W-1:0]  v1_s5_reg;
    sample_t                 p0_s5_reg;
    logic [T_W-1:0]          t_s5_reg;
    logic                    f_s5_reg;
    logic signed [PV2_W-1:0] r2;

    // stage 6: v1 * t
    logic signed [PV1_W-1:0] pv1_s6_reg;
    sample_t                 p0_s6_reg;
    logic                    f_s6_reg;
    logic signed [PV1_W-1:0] r1;

    // stage 7: output register
    sample_t                 y_s7_reg;
    logic                    f_s7_reg;
    logic signed [Y_W-1:0]   y_sum, y_sat;

    // per-stage advance, a stage moves when it is empty or the next one moves
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // c2 = 4p1 + 2m1 - 5p0 - p2, c3 = 3(p0 - p1) - m1 + p2
    assign d_pp    = C_W'(in_taps.p0) - C_W'(in_taps.p1);
    assign c2_next = (C_W'(in_taps.p1) <<< 2) + (C_W'(in_taps.m1) <<< 1)
                     - (C_W'(in_taps.p0) <<< 2) - C_W'(in_taps.p0) - C_W'(in_taps.p2);
    assign c3_next = d_pp + (d_pp <<< 1) - C_W'(in_taps.m1) + C_W'(in_taps.p2);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            c1_s1_reg <= C1_W'(in_taps.p1) - C1_W'(in_taps.m1);
            c2_s1_reg <= c2_next;
            c3_s1_reg <= c3_next;
            p0_s1_reg <= in_taps.p0;
            t_s1_reg  <= in_taps.t;
            f_s1_reg  <= in_taps.flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            c3t_s2_reg <= C3T_W'(c3_s1_reg) * C3T_W'($signed({1'b0, t_s1_reg}));
            c1_s2_reg  <= c1_s1_reg;
            c2_s2_reg  <= c2_s1_reg;
            p0_s2_reg  <= p0_s1_reg;
            t_s2_reg   <= t_s1_reg;
            f_s2_reg   <= f_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            v2_s3_reg <= (V2_W'(c2_s2_reg) <<< T_W) + V2_W'(c3t_s2_reg);
            c1_s3_reg <= c1_s2_reg;
            p0_s3_reg <= p0_s2_reg;
            t_s3_reg  <= t_s2_reg;
            f_s3_reg  <= f_s2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            pv2_s4_reg <= PV2_W'(v2_s3_reg) * PV2_W'($signed({1'b0, t_s3_reg}));
            c1_s4_reg  <= c1_s3_reg;
            p0_s4_reg  <= p0_s3_reg;
            t_s4_reg   <= t_s3_reg;
            f_s4_reg   <= f_s3_reg;
        end
    end

    // round half up, then drop the fraction
    assign r2 = pv2_s4_reg + RND2;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            v1_s5_reg <= (V1_W'(c1_s4_reg) <<< T_W) + V1_W'($signed(r2[PV2_W-1:T_W]));
            p0_s5_reg <= p0_s4_reg;
            t_s5_reg  <= t_s4_reg;
            f_s5_reg  <= f_s4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            pv1_s6_reg <= PV1_W'(v1_s5_reg) * PV1_W'($signed({1'b0, t_s5_reg}));
            p0_s6_reg  <= p0_s5_reg;
            f_s6_reg   <= f_s5_reg;
        end
    end

    // final scale carries the catmull-rom one half
    assign r1    = pv1_s6_reg + RND1;
    assign y_sum = Y_W'($signed(r1[PV1_W-1:Q_SH])) + Y_W'(p0_s6_reg);

    always_comb begin
        if (y_sum > Y_MAX) begin
            y_sat = Y_MAX;
        end else if (y_sum < Y_MIN) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = y_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            y_s7_reg <= y_sat[SAMPLE_W-1:0];
            f_s7_reg <= f_s6_reg;
        end
    end

    assign out_valid    = vld_reg[NS-1];
    assign y_value      = y_s7_reg;
    assign out_of_range = f_s7_reg;

endmodule

[rtl/core/cubic_table_interpolator.sv]
// top level of the table lookup function generator with cubic interpolation
//
// input stream: one transfer per request; s_tuser selects a table write or an
// evaluation. a write stores a Q1.15 entry and gives no result; an evaluation
// maps x_value to a table position through x_scale and x_offset, reads four
// neighbouring entries and returns one Q1.15 result on the output stream with
// m_tuser set when the index had to be clamped into 1..length-3.
// configuration: a plain write port, cfg_wr_index selects x_scale, x_offset or
// the table length; write it only while no request is in flight.
// throughput: one request per cycle while m_tready is high; the table sits in
// four banks addressed by the low index bits so the four neighbours come from
// one read of every bank, and a write and a read never compete for a port.
// pipeline: three mapping stages, one table read and seven polynomial stages
// ending in the output register.
// reset: pipeline valid bits clear and the registers return to scale 1.0,
// offset 1.0 and length 1024; table contents stay undefined until written.
// stall: every stage holds its item while the next is full and not moving,
// so input transfers keep flowing into empty stages while a result waits.
module cubic_table_interpolator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [ctbl_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [ctbl_pkg::CFG_W-1:0]         cfg_wr_data,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // table_addr [9:0], table_data [25:10], x_value [41:26], zero fill [47:42]
    input  logic [ctbl_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type [0]
    input  logic                               s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // y_value [15:0]
    output logic [ctbl_pkg::M_TDATA_W-1:0]     m_tdata,
    // out_of_range [0]
    output logic                               m_tuser
);
    import ctbl_pkg::*;

    // configuration registers
    logic signed [CFG_W-1:0] x_scale_reg;
    logic signed [CFG_W-1:0] x_offset_reg;
    logic [LEN_W-1:0]        tbl_len_reg;

    // links between the pipeline sections
    req_t    in_req;
    logic    map_valid, map_ready;
    lookup_t map_lookup;
    logic    tap_valid, tap_ready;
    taps_t   taps;
    sample_t y_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_scale_reg  <= CFG_W'(65536);
            x_offset_reg <= CFG_W'(65536);
            tbl_len_reg  <= LEN_W'(1024);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_X_SCALE: begin
                    x_scale_reg <= $signed(cfg_wr_data);
                end
                REG_X_OFFSET: begin
                    x_offset_reg <= $signed(cfg_wr_data);
                end
                REG_TBL_LEN: begin
                    tbl_len_reg <= cfg_wr_data[LEN_W-1:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // unpack the request transfer
    assign in_req.req_type   = s_tuser;
    assign in_req.table_addr = s_tdata[ADDR_LSB +: ADDR_W];
    assign in_req.table_data = s_tdata[DATA_LSB +: SAMPLE_W];
    assign in_req.x_value    = s_tdata[X_LSB +: X_W];

    // position mapping and clamping
    ctbl_mapper #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mapper (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .x_scale      (x_scale_reg),
        .x_offset     (x_offset_reg),
        .tbl_len      (tbl_len_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_req       (in_req),
        .out_valid    (map_valid),
        .out_ready    (map_ready),
        .out_lookup   (map_lookup)
    );

    // banked table, writes land here in request order
    ctbl_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (map_valid),
        .in_ready  (map_ready),
        .in_lookup (map_lookup),
        .out_valid (tap_valid),
        .out_ready (tap_ready),
        .out_taps  (taps)
    );

    // polynomial evaluation and saturation
    ctbl_hermite u_hermite (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (tap_valid),
        .in_ready     (tap_ready),
        .in_taps      (taps),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .y_value      (y_value),
        .out_of_range (m_tuser)
    );

    assign m_tdata = y_value;

    // a consumer that takes results never backs up the input
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled although the output side is ready");

endmodule
